// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the delta filter codec.
// Each takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/dfc_pkg.sv =====
`timescale 1ns / 1ps

package dfc_pkg;

    localparam logic [7:0]  MAGIC_BYTE  = 8'h80;
    localparam logic [7:0]  MAGIC_HALF  = 8'h81;
    localparam logic [23:0] LEN_MAX     = 24'hFF_FFFF;

    // header_index value once all four header bytes are in
    localparam logic [2:0]  HDR_DONE    = 3'd4;

    localparam int          MAX_RESULTS = 6;
    localparam int          CNT_W       = $clog2(MAX_RESULTS + 1);

    // status codes
    localparam logic [1:0]  ST_OK         = 2'd0;
    localparam logic [1:0]  ST_BAD_MAGIC  = 2'd1;
    localparam logic [1:0]  ST_BAD_LENGTH = 2'd2;
    localparam logic [1:0]  ST_TRUNCATED  = 2'd3;

    // config register indexes
    localparam logic [1:0]  REG_DIRECTION    = 2'd0;
    localparam logic [1:0]  REG_SAMPLE_WIDTH = 2'd1;
    localparam logic [1:0]  REG_ENCODE_LEN   = 2'd2;
    localparam logic [1:0]  REG_MAX_OUT_LEN  = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       last;
    } t_result;

    // all results caused by one item, entry 0 goes out first
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] ents;
        logic [CNT_W-1:0]          cnt;
    } t_burst;

endpackage

// ===== hw/rtl/dfc_step.sv =====
`timescale 1ns / 1ps

// Config registers, stream state and the per-item result list.
module dfc_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  logic                i_load,
    input  logic [7:0]          i_in_byte,
    input  logic                i_end_of_stream,
    output dfc_pkg::t_burst     o_burst
);

    typedef struct packed {
        logic        direction;
        logic        sample_width;
        logic [23:0] encode_length;
        logic [23:0] max_output_length;
    } t_cfg;

    t_cfg        r_cfg;

    logic [2:0]  r_hidx,  n_hidx;
    logic [23:0] r_decl,  n_decl;
    logic [23:0] r_done,  n_done;
    logic [15:0] r_rv,    n_rv;
    logic [7:0]  r_held,  n_held;
    logic        r_pend,  n_pend;
    logic        r_failed, n_failed;

    logic                       complete;
    logic                       post_complete;
    logic [7:0]                 magic;
    logic [23:0]                len;
    logic [23:0]                dl;
    logic [23:0]                done1;
    logic [23:0]                done2;
    logic [7:0]                 sum8;
    logic [15:0]                val16;
    logic [15:0]                diff16;
    logic [dfc_pkg::CNT_W-1:0]  cnt;
    dfc_pkg::t_burst            burst;

    function automatic dfc_pkg::t_result mk(input logic [7:0] b, input logic v,
                                           input logic [1:0] st, input logic l);
        dfc_pkg::t_result r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.status     = st;
        r.last       = l;
        return r;
    endfunction

    assign complete = (r_hidx == dfc_pkg::HDR_DONE) && (r_done >= r_decl);
    assign magic    = r_cfg.sample_width ? dfc_pkg::MAGIC_HALF : dfc_pkg::MAGIC_BYTE;
    assign done1    = r_done + 24'd1;
    assign done2    = r_done + 24'd2;
    assign sum8     = r_rv[7:0] + i_in_byte;
    assign dl       = (r_hidx == dfc_pkg::HDR_DONE) ? r_decl : r_cfg.encode_length;

    always_comb begin
        case (r_hidx)
            3'd1:    len = {r_decl[23:8], i_in_byte};
            3'd2:    len = {r_decl[23:16], i_in_byte, r_decl[7:0]};
            default: len = {i_in_byte, r_decl[15:0]};
        endcase
    end

    always_comb begin
        n_hidx   = r_hidx;
        n_decl   = r_decl;
        n_done   = r_done;
        n_rv     = r_rv;
        n_held   = r_held;
        n_pend   = r_pend;
        n_failed = r_failed;
        burst    = '0;
        cnt      = '0;
        val16    = '0;
        diff16   = '0;
        post_complete = 1'b0;

        if (!r_failed && !complete) begin
            if (!r_cfg.direction) begin
                // decode
                if (r_hidx != dfc_pkg::HDR_DONE) begin
                    if (r_hidx == 3'd0) begin
                        if (i_in_byte != magic) begin
                            burst.ents[cnt] = mk(8'd0, 1'b0, dfc_pkg::ST_BAD_MAGIC, 1'b1);
                            cnt = cnt + 1'b1;
                            n_failed = 1'b1;
                        end else begin
                            n_hidx = 3'd1;
                        end
                    end else begin
                        n_decl = len;
                        n_hidx = r_hidx + 3'd1;
                        if (r_hidx == 3'd3) begin
                            if (len == 24'd0 || len > r_cfg.max_output_length) begin
                                burst.ents[cnt] = mk(8'd0, 1'b0, dfc_pkg::ST_BAD_LENGTH, 1'b1);
                                cnt = cnt + 1'b1;
                                n_failed = 1'b1;
                            end else if (r_cfg.sample_width && len == 24'd1) begin
                                // lone odd byte: emit the zero tail right away
                                burst.ents[cnt] = mk(8'd0, 1'b1, dfc_pkg::ST_OK, 1'b1);
                                cnt = cnt + 1'b1;
                                n_done = 24'd1;
                            end
                        end
                    end
                end else if (!r_cfg.sample_width) begin
                    n_rv   = {8'd0, sum8};
                    n_done = done1;
                    burst.ents[cnt] = mk(sum8, 1'b1, dfc_pkg::ST_OK, done1 == r_decl);
                    cnt = cnt + 1'b1;
                end else if (!r_pend) begin
                    n_held = i_in_byte;
                    n_pend = 1'b1;
                end else begin
                    val16  = r_rv + {i_in_byte, r_held};
                    n_rv   = val16;
                    n_pend = 1'b0;
                    burst.ents[cnt] = mk(val16[7:0], 1'b1, dfc_pkg::ST_OK, 1'b0);
                    cnt = cnt + 1'b1;
                    burst.ents[cnt] = mk(val16[15:8], 1'b1, dfc_pkg::ST_OK, done2 == r_decl);
                    cnt = cnt + 1'b1;
                    if ((r_decl - done2) == 24'd1) begin
                        // odd length: pad with one zero byte
                        burst.ents[cnt] = mk(8'd0, 1'b1, dfc_pkg::ST_OK, 1'b1);
                        cnt = cnt + 1'b1;
                        n_done = done1 + 24'd2;
                    end else begin
                        n_done = done2;
                    end
                end
            end else begin
                // encode
                if (r_hidx != dfc_pkg::HDR_DONE && r_cfg.encode_length == 24'd0) begin
                    burst.ents[cnt] = mk(8'd0, 1'b0, dfc_pkg::ST_BAD_LENGTH, 1'b1);
                    cnt = cnt + 1'b1;
                    n_failed = 1'b1;
                end else begin
                    if (r_hidx != dfc_pkg::HDR_DONE) begin
                        burst.ents[cnt] = mk(magic, 1'b1, dfc_pkg::ST_OK, 1'b0);
                        cnt = cnt + 1'b1;
                        burst.ents[cnt] = mk(dl[7:0], 1'b1, dfc_pkg::ST_OK, 1'b0);
                        cnt = cnt + 1'b1;
                        burst.ents[cnt] = mk(dl[15:8], 1'b1, dfc_pkg::ST_OK, 1'b0);
                        cnt = cnt + 1'b1;
                        burst.ents[cnt] = mk(dl[23:16], 1'b1, dfc_pkg::ST_OK, 1'b0);
                        cnt = cnt + 1'b1;
                        n_hidx = dfc_pkg::HDR_DONE;
                        n_decl = dl;
                    end
                    n_done = done1;
                    if (!r_cfg.sample_width) begin
                        n_rv = {8'd0, i_in_byte};
                        burst.ents[cnt] = mk(i_in_byte - r_rv[7:0], 1'b1, dfc_pkg::ST_OK,
                                             done1 == dl);
                        cnt = cnt + 1'b1;
                    end else begin
                        n_held = r_pend ? r_held : i_in_byte;
                        if (!r_pend && done1 != dl) begin
                            n_pend = 1'b1;
                        end else begin
                            // full pair, or odd tail with a zero high byte
                            val16  = r_pend ? {i_in_byte, r_held} : {8'd0, i_in_byte};
                            diff16 = val16 - r_rv;
                            n_rv   = val16;
                            n_pend = 1'b0;
                            burst.ents[cnt] = mk(diff16[7:0], 1'b1, dfc_pkg::ST_OK, 1'b0);
                            cnt = cnt + 1'b1;
                            burst.ents[cnt] = mk(diff16[15:8], 1'b1, dfc_pkg::ST_OK,
                                                 done1 == dl);
                            cnt = cnt + 1'b1;
                        end
                    end
                end
            end

            post_complete = (n_hidx == dfc_pkg::HDR_DONE) && (n_done >= n_decl);
            if (i_end_of_stream && !n_failed && !post_complete) begin
                burst.ents[cnt] = mk(8'd0, 1'b0, dfc_pkg::ST_TRUNCATED, 1'b1);
                cnt = cnt + 1'b1;
            end
        end
        burst.cnt = cnt;
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction         <= 1'b0;
            r_cfg.sample_width      <= 1'b0;
            r_cfg.encode_length     <= 24'd0;
            r_cfg.max_output_length <= dfc_pkg::LEN_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dfc_pkg::REG_DIRECTION:    r_cfg.direction         <= i_cfg_data[0];
                dfc_pkg::REG_SAMPLE_WIDTH: r_cfg.sample_width      <= i_cfg_data[0];
                dfc_pkg::REG_ENCODE_LEN:   r_cfg.encode_length     <= i_cfg_data;
                dfc_pkg::REG_MAX_OUT_LEN:  r_cfg.max_output_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stream state: cleared by reset, any config write and end of stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_load && i_end_of_stream)) begin
            r_hidx   <= 3'd0;
            r_decl   <= 24'd0;
            r_done   <= 24'd0;
            r_rv     <= 16'd0;
            r_held   <= 8'd0;
            r_pend   <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_load) begin
            r_hidx   <= n_hidx;
            r_decl   <= n_decl;
            r_done   <= n_done;
            r_rv     <= n_rv;
            r_held   <= n_held;
            r_pend   <= n_pend;
            r_failed <= n_failed;
        end
    end

endmodule

// ===== hw/rtl/dfc_burst.sv =====
`timescale 1ns / 1ps

// Result register: holds one item's results and hands them out one a cycle while the output is not stalled.
module dfc_burst (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  dfc_pkg::t_burst             i_burst,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output dfc_pkg::t_result            o_head,
    output logic [dfc_pkg::CNT_W-1:0]   o_cnt,
    output logic                        o_can_load
);

    dfc_pkg::t_result [dfc_pkg::MAX_RESULTS-1:0] r_ent;
    logic [dfc_pkg::CNT_W-1:0]                  r_cnt;
    logic                                       pop;

    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_can_load  = (r_cnt == '0) || ((r_cnt == dfc_pkg::CNT_W'(1)) && !i_out_stall);
    assign o_head      = r_ent[0];
    assign o_cnt       = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_burst.ents;
        end else if (pop) begin
            for (int i = 0; i < dfc_pkg::MAX_RESULTS - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
    end

endmodule

// ===== hw/rtl/delta_filter_codec.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Handshake               Payload
// in        in   i_in_valid/o_in_stall   i_in_byte, i_end_of_stream
// out       out  o_out_valid/i_out_stall o_out_byte, o_byte_valid, o_status, o_last
// cfg       in   i_cfg_we                i_cfg_index, i_cfg_data
//
// One item per cycle when items make at most one result and the output is not
// stalled; an item with more results (header bytes, halfword pairs, status)
// holds the input until the result register, which drains one entry a cycle,
// is at its last entry. An item's first result shows the cycle after it is taken.
// Reset is synchronous, active low; it clears config and stream state.
// An output stall holds the head result and stalls the input once one
// result is left in the register.
module delta_filter_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [1:0]  o_status,
    output logic        o_last
);

    dfc_pkg::t_burst                w_burst;
    dfc_pkg::t_result               w_head;
    logic [dfc_pkg::CNT_W-1:0]      w_cnt;
    logic                           w_can_load;
    logic                           w_accept;

    // item is taken when the result register is empty or about to be
    assign o_in_stall = !w_can_load;
    assign w_accept   = i_in_valid && w_can_load;

    dfc_step u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_load          (w_accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_burst         (w_burst)
    );

    dfc_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_burst     (w_burst),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_head      (w_head),
        .o_cnt       (w_cnt),
        .o_can_load  (w_can_load)
    );

    assign o_out_byte   = w_head.out_byte;
    assign o_byte_valid = w_head.byte_valid;
    assign o_status     = w_head.status;
    assign o_last       = w_head.last;

    // error and truncation reports are status-only, and always end the stream
    `ASSERT_IMPLY(a_status_last, i_clk, i_rst_n, o_out_valid && o_status != dfc_pkg::ST_OK, o_last && !o_byte_valid)
    // status-only results carry a zero byte
    `ASSERT_IMPLY(a_status_zero, i_clk, i_rst_n, o_out_valid && !o_byte_valid, o_out_byte == 8'd0)
    // the result register never holds more than one item's results
    `ASSERT_IMPLY(a_cnt_bound, i_clk, i_rst_n, 1'b1, w_cnt <= dfc_pkg::CNT_W'(dfc_pkg::MAX_RESULTS))
    // a drained result without a new item shortens the queue by one
    `ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, o_out_valid && !i_out_stall && !w_accept, w_cnt == $past(w_cnt) - 1'b1)

endmodule

// ===== dv/delta_filter_codec_test.sv =====
`timescale 1ns / 1ps

// Tracks the codec's stream state and queues the bytes it should produce.
class codec_scoreboard;
    // register copies
    bit          dir_encode;
    bit          half_mode;
    logic [23:0] enc_len_reg;
    logic [23:0] max_len_reg;

    // stream state
    logic [2:0]  hdr_count;
    logic [23:0] length_seen;
    logic [23:0] bytes_count;
    logic [15:0] acc;
    logic [7:0]  low_held;
    bit          pair_open;
    bit          failed;

    dfc_pkg::t_result expected_bytes[$];
    int unsigned      error_count;

    function new();
        dir_encode  = 1'b0;
        half_mode   = 1'b0;
        enc_len_reg = '0;
        max_len_reg = dfc_pkg::LEN_MAX;
        error_count = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        hdr_count   = '0;
        length_seen = '0;
        bytes_count = '0;
        acc         = '0;
        low_held    = '0;
        pair_open   = 1'b0;
        failed      = 1'b0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    // any register write restarts the stream
    function void write_reg(logic [1:0] idx, logic [23:0] val);
        case (idx)
            dfc_pkg::REG_DIRECTION:    dir_encode  = val[0];
            dfc_pkg::REG_SAMPLE_WIDTH: half_mode   = val[0];
            dfc_pkg::REG_ENCODE_LEN:   enc_len_reg = val;
            dfc_pkg::REG_MAX_OUT_LEN:  max_len_reg = val;
            default: ;
        endcase
        clear_stream();
    endfunction

    function void push(logic [7:0] b, bit v, logic [1:0] st, bit lst);
        dfc_pkg::t_result r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.status     = st;
        r.last       = lst;
        expected_bytes.push_back(r);
    endfunction

    function bit complete();
        return (hdr_count >= dfc_pkg::HDR_DONE) && (bytes_count >= length_seen);
    endfunction

    function void abort(logic [1:0] st);
        push(8'h00, 1'b0, st, 1'b1);
        failed = 1'b1;
    endfunction

    function void decode_step(logic [7:0] b);
        if (hdr_count < dfc_pkg::HDR_DONE) begin
            if (hdr_count == 3'd0) begin
                if (b != (half_mode ? dfc_pkg::MAGIC_HALF : dfc_pkg::MAGIC_BYTE)) begin
                    abort(dfc_pkg::ST_BAD_MAGIC);
                    return;
                end
            end else begin
                length_seen = length_seen | ({16'h0000, b} << (8 * (hdr_count - 3'd1)));
            end
            hdr_count = hdr_count + 3'd1;
            if (hdr_count == dfc_pkg::HDR_DONE) begin
                if (length_seen == 24'd0 || length_seen > max_len_reg) begin
                    abort(dfc_pkg::ST_BAD_LENGTH);
                end else if (half_mode && length_seen == 24'd1) begin
                    // one-byte halfword stream: lone zero byte at once
                    push(8'h00, 1'b1, dfc_pkg::ST_OK, 1'b1);
                    bytes_count = 24'd1;
                end
            end
            return;
        end
        if (!half_mode) begin
            acc         = {8'h00, acc[7:0] + b};
            bytes_count = bytes_count + 24'd1;
            push(acc[7:0], 1'b1, dfc_pkg::ST_OK, bytes_count == length_seen);
            return;
        end
        if (!pair_open) begin
            low_held  = b;
            pair_open = 1'b1;
            return;
        end
        pair_open   = 1'b0;
        acc         = acc + {b, low_held};
        bytes_count = bytes_count + 24'd2;
        push(acc[7:0], 1'b1, dfc_pkg::ST_OK, 1'b0);
        push(acc[15:8], 1'b1, dfc_pkg::ST_OK, bytes_count == length_seen);
        // odd length: pad the tail with a zero byte
        if (length_seen - bytes_count == 24'd1) begin
            push(8'h00, 1'b1, dfc_pkg::ST_OK, 1'b1);
            bytes_count = bytes_count + 24'd1;
        end
    endfunction

    function void emit_pair(logic [15:0] val);
        logic [15:0] d;
        d         = val - acc;
        acc       = val;
        pair_open = 1'b0;
        push(d[7:0], 1'b1, dfc_pkg::ST_OK, 1'b0);
        push(d[15:8], 1'b1, dfc_pkg::ST_OK, bytes_count == length_seen);
    endfunction

    function void encode_step(logic [7:0] b);
        logic [7:0] d;
        if (hdr_count < dfc_pkg::HDR_DONE) begin
            length_seen = enc_len_reg;
            if (length_seen == 24'd0) begin
                abort(dfc_pkg::ST_BAD_LENGTH);
                return;
            end
            push(half_mode ? dfc_pkg::MAGIC_HALF : dfc_pkg::MAGIC_BYTE, 1'b1,
                 dfc_pkg::ST_OK, 1'b0);
            push(length_seen[7:0], 1'b1, dfc_pkg::ST_OK, 1'b0);
            push(length_seen[15:8], 1'b1, dfc_pkg::ST_OK, 1'b0);
            push(length_seen[23:16], 1'b1, dfc_pkg::ST_OK, 1'b0);
            hdr_count = dfc_pkg::HDR_DONE;
        end
        if (!half_mode) begin
            d           = b - acc[7:0];
            acc         = {8'h00, b};
            bytes_count = bytes_count + 24'd1;
            push(d, 1'b1, dfc_pkg::ST_OK, bytes_count == length_seen);
            return;
        end
        bytes_count = bytes_count + 24'd1;
        if (!pair_open) begin
            low_held  = b;
            pair_open = 1'b1;
            if (bytes_count == length_seen)
                emit_pair({8'h00, low_held});
            return;
        end
        emit_pair({b, low_held});
    endfunction

    function void note_item(logic [7:0] b, logic eos);
        if (!failed && !complete()) begin
            if (!dir_encode)
                decode_step(b);
            else
                encode_step(b);
            if (eos && !failed && !complete())
                push(8'h00, 1'b0, dfc_pkg::ST_TRUNCATED, 1'b1);
        end
        if (eos)
            clear_stream();
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    endfunction

    function void check_item(dfc_pkg::t_result got);
        dfc_pkg::t_result want;
        if (expected_bytes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual byte %0h valid %0b",
                     $time, got.out_byte, got.byte_valid);
            $display("%0t: unexpected result, expected none, actual status %0d last %0b",
                     $time, got.status, got.last);
            return;
        end
        want = expected_bytes.pop_front();
        if (want.out_byte !== got.out_byte)
            report_field("out_byte", want.out_byte, got.out_byte);
        if (want.byte_valid !== got.byte_valid)
            report_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, got.byte_valid});
        if (want.status !== got.status)
            report_field("status", {6'd0, want.status}, {6'd0, got.status});
        if (want.last !== got.last)
            report_field("last", {7'd0, want.last}, {7'd0, got.last});
    endfunction
endclass

module delta_filter_codec_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;     // quiet cycles after the last expected byte
    localparam int RANDOM_ITEMS = 470;
    localparam int HOLD_CYCLES  = 64;    // long receiver hold-off

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_end_of_stream;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic [1:0]  o_status;
    logic        o_last;

    codec_scoreboard sb = new();

    // idling knobs, percent per cycle
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;          // set by stimulus, consumed by the receiver process
    int live_items;
    int stream_no;
    int cycle_count;

    delta_filter_codec DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Monitor: both channels sampled at the rising edge. Input items go to the
    // predictor first; a result never comes out in the edge its item goes in.
    always @(posedge i_clk) begin : monitor
        dfc_pkg::t_result got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_in_byte, i_end_of_stream);
            if (o_out_valid && !i_out_stall) begin
                got.out_byte   = o_out_byte;
                got.byte_valid = o_byte_valid;
                got.status     = o_status;
                got.last       = o_last;
                sb.check_item(got);
            end
        end
    end

    // Receiver: random stall per cycle, or a long hold-off when asked.
    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic set_mode(input int m);
        case (m)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    // Entered and left at a falling edge. Holds the item until it is taken.
    task automatic send_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid, wait until every expected byte is out, then a few quiet cycles
    // in case the block is still finishing an item that makes no result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes all four registers back to back, only once the block is idle.
    task automatic set_config(input bit enc, input bit hw, input logic [23:0] enc_len,
                              input logic [23:0] max_len);
        logic [1:0]  regs [4];
        logic [23:0] vals [4];
        regs[0] = dfc_pkg::REG_DIRECTION;    vals[0] = {23'd0, enc};
        regs[1] = dfc_pkg::REG_SAMPLE_WIDTH; vals[1] = {23'd0, hw};
        regs[2] = dfc_pkg::REG_ENCODE_LEN;   vals[2] = enc_len;
        regs[3] = dfc_pkg::REG_MAX_OUT_LEN;  vals[3] = max_len;
        settle();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.write_reg(regs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Directed helper: up to 8 bytes, first byte in the top lane, eos on the last.
    task automatic send_packed(input logic [63:0] seq, input int cnt);
        for (int k = 0; k < cnt; k++)
            send_item(seq[8*(cnt-1-k) +: 8], k == cnt - 1);
    endtask

    // Mostly well-formed streams with random content; some broken on purpose.
    task automatic run_random_stream();
        bit          enc;
        bit          hw;
        logic [23:0] len;
        logic [23:0] max_len;
        logic [7:0]  hdr [4];
        logic [7:0]  b;
        int unsigned plan;
        int unsigned total;
        bit          truncate;
        enc = 1'($urandom_range(1));
        hw  = 1'($urandom_range(1));
        case ($urandom_range(11))
            0: len = 24'd0;
            1: len = dfc_pkg::LEN_MAX;
            2: len = 24'($urandom);
            3: len = 24'd1;
            default: len = 24'($urandom_range(14, 2));
        endcase
        case ($urandom_range(7))
            0: max_len = 24'd1;
            1: max_len = 24'($urandom_range(12, 1));
            2: max_len = 24'($urandom_range(24'hFF_FFFF, 1));
            default: max_len = dfc_pkg::LEN_MAX;
        endcase
        set_config(enc, hw, len, max_len);
        if (!enc) begin
            // occasional corrupt magic
            if ($urandom_range(9) == 0)
                hdr[0] = 8'($urandom);
            else
                hdr[0] = hw ? dfc_pkg::MAGIC_HALF : dfc_pkg::MAGIC_BYTE;
            hdr[1] = len[7:0];
            hdr[2] = len[15:8];
            hdr[3] = len[23:16];
            // an odd halfword length takes one byte less than it declares
            plan = 4 + int'(hw ? {len[23:1], 1'b0} : len);
        end else begin
            plan = (len == 24'd0) ? 1 : int'(len);
        end
        truncate = ($urandom_range(6) == 0) || (plan > 20);
        if (truncate)
            total = (plan > 20) ? $urandom_range(20, 1)
                                : $urandom_range(plan > 1 ? plan - 1 : 1, 1);
        else
            total = plan + (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
        for (int unsigned k = 0; k < total; k++) begin
            if (!enc && k < 4)
                b = hdr[k];
            else
                b = 8'($urandom);
            send_item(b, k == total - 1);
            if (k < plan)
                live_items++;
        end
    endtask

    // Noise: a few random bytes under whatever setting is in place.
    task automatic junk_stream();
        int unsigned cnt;
        cnt = $urandom_range(6, 1);
        for (int unsigned k = 0; k < cnt; k++)
            send_item(8'($urandom), (k == cnt - 1) || ($urandom_range(7) == 0));
        live_items++;
    endtask

    // Long byte encode while the receiver holds off: the block fills up and
    // stalls its input while the sender keeps offering items.
    task automatic pressure_stream();
        set_config(1'b1, 1'b0, 24'd48, dfc_pkg::LEN_MAX);
        hold_req = HOLD_CYCLES;
        for (int k = 0; k < 48; k++)
            send_item(8'($urandom), k == 47);
        live_items += 48;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = dfc_pkg::REG_DIRECTION;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_in_byte       = '0;
        i_end_of_stream = 1'b0;
        hold_req        = 0;
        live_items      = 0;
        stream_no       = 0;
        set_mode(0);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // byte decode, length 2, extremes of the delta, a trailing byte ignored
        set_config(1'b0, 1'b0, 24'd0, dfc_pkg::LEN_MAX);
        send_packed(64'h80_02_00_00_FF_01_AA, 7);
        // wrong magic for byte mode
        send_packed(64'h81, 1);
        // halfword decode: length one gives a lone zero byte, length zero is bad
        set_config(1'b0, 1'b1, 24'd0, dfc_pkg::LEN_MAX);
        send_packed(64'h81_01_00_00, 4);
        send_packed(64'h81_00_00_00, 4);
        // source ends inside the header
        send_packed(64'h81_03, 2);
        // byte encode, one byte
        set_config(1'b1, 1'b0, 24'd1, dfc_pkg::LEN_MAX);
        send_packed(64'hFF, 1);
        // halfword encode, odd length pads the tail
        set_config(1'b1, 1'b1, 24'd3, dfc_pkg::LEN_MAX);
        send_packed(64'h00_FF_12, 3);
        // encode with a zero length register
        set_config(1'b1, 1'b0, 24'd0, dfc_pkg::LEN_MAX);
        send_packed(64'h55, 1);
        // declared length above the smallest limit
        set_config(1'b0, 1'b0, 24'd5, 24'd1);
        send_packed(64'h80_02_00_00, 4);

        // random part, idling mode rotates every few streams
        while (live_items < RANDOM_ITEMS) begin
            set_mode((stream_no / 6) % 4);
            if (stream_no == 3 || stream_no == 40)
                pressure_stream();
            else if ($urandom_range(11) == 0)
                junk_stream();
            else
                run_random_stream();
            stream_no++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== delta_filter_codec.f =====
+incdir+hw/rtl
hw/rtl/dfc_pkg.sv
hw/rtl/dfc_step.sv
hw/rtl/dfc_burst.sv
hw/rtl/delta_filter_codec.sv
dv/delta_filter_codec_test.sv
